/* src/frame_ring_queue_assert.svh */
// assertion macros for the frame ring queue
// used by the top level, which supplies clk and rst in scope
`ifndef FRAME_RING_QUEUE_ASSERT_SVH
`define FRAME_RING_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/frq_pkg.sv */
// shared types and codes for the frame ring queue
// no dependencies; imported by every module of the block
package frq_pkg;

  localparam int THRESH_W = 4;
  localparam int LEN_W    = 12;
  localparam int CNT_OUT_W = 3;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_POP_EMPTY = 2'd1;
  localparam logic [1:0] STAT_DROP_FULL = 2'd2;
  localparam logic [1:0] STAT_DROP_LONG = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] push_byte;
    logic       push_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           pop_byte;
    logic                 pop_last;
    logic [LEN_W-1:0]     frame_length;
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] frames_stored;
    logic [CNT_OUT_W-1:0] free_slots;
    logic                 above_threshold;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take_item;
    logic move_out;
  } frq_cmd_t;

endpackage

/* src/frq_ctrl.sv */
// handshake controller for the frame ring queue
// depends on frq_pkg; drives the datapath through frq_cmd_t
module frq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  output logic            result_valid,
  input  logic            result_ready,
  output frq_pkg::frq_cmd_t cmd
);
  import frq_pkg::*;

  localparam logic ST_EMPTY  = 1'b0;
  localparam logic ST_STAGED = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;

  always_comb begin
    cmd.move_out   = (state == ST_STAGED) && (!out_valid || result_ready);
    item_ready     = (state == ST_EMPTY) || cmd.move_out;
    cmd.take_item  = item_valid && item_ready;
    out_valid_next = cmd.move_out || (out_valid && !result_ready);
    case (state)
      ST_EMPTY: begin
        state_next = cmd.take_item ? ST_STAGED : ST_EMPTY;
      end
      ST_STAGED: begin
        state_next = (cmd.move_out && !cmd.take_item) ? ST_EMPTY : ST_STAGED;
      end
      default: begin
        state_next = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_EMPTY;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign result_valid = out_valid;

endmodule

/* src/frq_dp.sv */
// datapath of the frame ring queue: pointers, frame and length memories,
// staging and output registers; depends on frq_pkg
module frq_dp #(
  parameter int QUEUE_SLOTS     = 8,
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  frq_pkg::frq_cmd_t               cmd,
  input  frq_pkg::in_item_t               item,
  input  logic                            cfg_write,
  input  logic [frq_pkg::THRESH_W-1:0]    cfg_data,
  output frq_pkg::out_item_t              result
);
  import frq_pkg::*;

  localparam int SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int OFF_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int RD_W   = $clog2(MAX_FRAME_BYTES);
  localparam int DEPTH  = QUEUE_SLOTS * MAX_FRAME_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = (SLOT_W > THRESH_W) ? SLOT_W : THRESH_W;
  localparam int LEN_X  = (OFF_W > LEN_W) ? OFF_W : LEN_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
  localparam logic [OFF_W-1:0]  MAX_OFF   = OFF_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_SLOTS - 1);
  localparam logic [ADDR_W-1:0] STRIDE    = ADDR_W'(MAX_FRAME_BYTES);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] count_of(input logic [SLOT_W-1:0] w,
                                                input logic [SLOT_W-1:0] r);
    logic [SLOT_W:0] diff;
    if (w >= r) begin
      diff = {1'b0, w} - {1'b0, r};
    end else begin
      diff = {1'b0, w} + (SLOT_W + 1)'(QUEUE_SLOTS) - {1'b0, r};
    end
    return CNT_W'(diff[SLOT_W-1:0]);
  endfunction

  // storage
  logic [7:0]       frame_mem [DEPTH];
  logic [OFF_W-1:0] len_mem   [QUEUE_SLOTS];

  // pointer state
  logic [SLOT_W-1:0]   write_slot, write_slot_next;
  logic [SLOT_W-1:0]   read_slot, read_slot_next;
  logic [OFF_W-1:0]    write_offset, write_offset_next;
  logic [RD_W-1:0]     read_offset, read_offset_next;
  logic                dropping, dropping_next;
  logic [THRESH_W-1:0] threshold;

  // length of the frame at the head, read ahead
  logic [OFF_W-1:0]  len_q;
  logic [SLOT_W-1:0] len_rd_slot;
  logic [7:0]        rd_byte;

  // staging register
  logic             st_pop_ok;
  logic             st_last;
  logic [OFF_W-1:0] st_len;
  logic [1:0]       st_status;
  logic [CNT_W-1:0] st_count;
  logic             st_above;

  // item decode
  logic             mem_we;
  logic             len_we;
  logic             pop_ok;
  logic             pop_last;
  logic [1:0]       status_n;
  logic [OFF_W-1:0] wo_inc;
  logic [OFF_W-1:0] rd_inc;
  logic [CNT_W-1:0] count_now;
  logic [CNT_W-1:0] count_after;
  logic [CNT_W-1:0] free_cnt;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    write_slot_next   = write_slot;
    read_slot_next    = read_slot;
    write_offset_next = write_offset;
    read_offset_next  = read_offset;
    dropping_next     = dropping;
    mem_we            = 1'b0;
    len_we            = 1'b0;
    pop_ok            = 1'b0;
    pop_last          = 1'b0;
    status_n          = STAT_OK;
    wo_inc            = write_offset + 1'b1;
    rd_inc            = OFF_W'(read_offset) + 1'b1;
    count_now         = count_of(write_slot, read_slot);
    if (item.kind == KIND_PUSH) begin
      if (dropping || write_offset >= MAX_OFF) begin
        status_n          = STAT_DROP_LONG;
        dropping_next     = !item.push_last;
        write_offset_next = '0;
      end else begin
        mem_we = 1'b1;
        if (item.push_last) begin
          if (count_now >= FULL_CNT) begin
            status_n = STAT_DROP_FULL;
          end else begin
            len_we          = 1'b1;
            write_slot_next = next_slot(write_slot);
          end
          write_offset_next = '0;
        end else begin
          write_offset_next = wo_inc;
        end
      end
    end else begin
      if (count_now == '0) begin
        status_n = STAT_POP_EMPTY;
      end else begin
        pop_ok = 1'b1;
        if (rd_inc >= len_q) begin
          pop_last         = 1'b1;
          read_offset_next = '0;
          read_slot_next   = next_slot(read_slot);
        end else begin
          read_offset_next = RD_W'(rd_inc);
        end
      end
    end
    count_after = count_of(write_slot_next, read_slot_next);
    len_rd_slot = cmd.take_item ? read_slot_next : read_slot;
    wr_addr     = ADDR_W'(write_slot) * STRIDE + ADDR_W'(write_offset);
    rd_addr     = ADDR_W'(read_slot) * STRIDE + ADDR_W'(read_offset);
    free_cnt    = FULL_CNT - st_count;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      read_slot    <= '0;
      write_offset <= '0;
      read_offset  <= '0;
      dropping     <= 1'b0;
      threshold    <= '0;
    end else begin
      if (cmd.take_item) begin
        write_slot   <= write_slot_next;
        read_slot    <= read_slot_next;
        write_offset <= write_offset_next;
        read_offset  <= read_offset_next;
        dropping     <= dropping_next;
      end
      if (cfg_write) begin
        threshold <= cfg_data;
      end
    end
  end

  // frame memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.take_item && mem_we) begin
      frame_mem[wr_addr] <= item.push_byte;
    end
    if (cmd.take_item) begin
      rd_byte <= frame_mem[rd_addr];
    end
  end

  // length memory, head entry read ahead with write bypass
  always_ff @(posedge clk) begin
    if (cmd.take_item && len_we) begin
      len_mem[write_slot] <= wo_inc;
    end
    if (cmd.take_item && len_we && write_slot == len_rd_slot) begin
      len_q <= wo_inc;
    end else begin
      len_q <= len_mem[len_rd_slot];
    end
  end

  // staging and output registers
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      st_pop_ok <= pop_ok;
      st_last   <= pop_last;
      st_len    <= len_q;
      st_status <= status_n;
      st_count  <= count_after;
      st_above  <= count_after >= CNT_W'(threshold);
    end
    if (cmd.move_out) begin
      result.pop_byte        <= st_pop_ok ? rd_byte : 8'h00;
      result.pop_last        <= st_last;
      result.frame_length    <= st_pop_ok ? LEN_W'(LEN_X'(st_len)) : '0;
      result.status          <= st_status;
      result.frames_stored   <= st_count[CNT_OUT_W-1:0];
      result.free_slots      <= free_cnt[CNT_OUT_W-1:0];
      result.above_threshold <= st_above;
    end
  end

endmodule

/* src/frame_ring_queue.sv */
// top level of the frame ring queue
// depends on frq_pkg, frq_ctrl, frq_dp and frame_ring_queue_assert.svh
//
// ring queue of network frames, one slot per frame with a stored length.
// a push transfer writes one byte of the frame being built; the byte marked
// last commits it, unless QUEUE_SLOTS-1 frames are already held (dropped,
// status 2) or the frame overran MAX_FRAME_BYTES (rest dropped up to the
// last byte, status 3). a pop transfer returns the next byte of the oldest
// frame with its length and a last mark; the last byte frees the slot. a pop
// on an empty queue gives status 1 and zero fields. every result carries the
// counts after the item. one item is taken per cycle unless a result is
// held back; a result goes through the staging register, with the frame
// memory read registered beside it, and then the output register, so one
// more item is taken while a result waits. the user writes fill_threshold
// over the cfg channel only while the block is idle; it is not enforced.
`include "frame_ring_queue_assert.svh"

module frame_ring_queue #(
  parameter int QUEUE_SLOTS     = 8,
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  frq_pkg::in_item_t            item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output frq_pkg::out_item_t           result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [frq_pkg::THRESH_W-1:0] cfg_data
);
  import frq_pkg::*;

  frq_cmd_t cmd;
  logic     cfg_write;

  // threshold register is always ready to take a write
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // handshake sequencing
  frq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  // pointers, memories and result registers
  frq_dp #(
    .QUEUE_SLOTS     (QUEUE_SLOTS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  // input only stalls while a finished result is held back
  `FRQ_ASSERT_NOW(a_stall_backpressure, !item_ready, result_valid && !result_ready, "input stalled with output free")

  // stored and free counts always add up to the usable capacity
  `FRQ_ASSERT_NOW(a_count_sum, result_valid, 3'(result.frames_stored + result.free_slots) == 3'(QUEUE_SLOTS - 1), "stored and free counts disagree")

  // the end of a frame is only reported on a good pop
  `FRQ_ASSERT_NOW(a_last_ok, result_valid && result.pop_last, result.status == STAT_OK && result.frame_length != '0, "last mark on a failed pop")

  // a waiting result stays valid and steady until its transfer
  `FRQ_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result moved while held")

endmodule

/* bench/frame_ring_queue_check.sv */
`timescale 1ns / 100ps
// checker for the frame ring queue: watches the item, result and cfg channels,
// predicts each result from its own copy of the queue and compares
// depends on frq_pkg only
module frame_ring_queue_check #(
  parameter int QUEUE_SLOTS     = 8,
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_ready,
  input  frq_pkg::in_item_t            item,
  input  logic                         result_valid,
  input  logic                         result_ready,
  input  frq_pkg::out_item_t           result,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [frq_pkg::THRESH_W-1:0] cfg_data,
  output int unsigned                  fail_count,
  output int unsigned                  pending
);
  import frq_pkg::*;

  logic [7:0]       frame_bytes [QUEUE_SLOTS*MAX_FRAME_BYTES];
  logic [LEN_W-1:0] slot_length [QUEUE_SLOTS];
  int unsigned      wr_slot;
  int unsigned      rd_slot;
  int unsigned      wr_off;
  int unsigned      rd_off;
  logic             dropping;
  logic [THRESH_W-1:0] fill_level;
  out_item_t        expected_results [$];
  int unsigned      mismatches;

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
  end

  function automatic int unsigned frames_held();
    return (wr_slot + QUEUE_SLOTS - rd_slot) % QUEUE_SLOTS;
  endfunction

  // works out the result of one accepted item and updates the queue copy
  task automatic predict_result(input in_item_t it);
    out_item_t   r;
    int unsigned cnt;
    int unsigned off;
    r = '0;
    r.status = STAT_OK;
    if (it.kind == KIND_PUSH) begin
      if (dropping || wr_off >= MAX_FRAME_BYTES) begin
        r.status = STAT_DROP_LONG;
        dropping = !it.push_last;
        wr_off   = 0;
      end else begin
        frame_bytes[wr_slot*MAX_FRAME_BYTES + wr_off] = it.push_byte;
        wr_off++;
        if (it.push_last) begin
          if (frames_held() >= QUEUE_SLOTS - 1) begin
            r.status = STAT_DROP_FULL;
          end else begin
            slot_length[wr_slot] = LEN_W'(wr_off);
            wr_slot = (wr_slot + 1) % QUEUE_SLOTS;
          end
          wr_off = 0;
        end
      end
    end else if (frames_held() == 0) begin
      r.status = STAT_POP_EMPTY;
    end else begin
      off = (rd_off >= MAX_FRAME_BYTES) ? MAX_FRAME_BYTES - 1 : rd_off;
      r.pop_byte     = frame_bytes[rd_slot*MAX_FRAME_BYTES + off];
      r.frame_length = slot_length[rd_slot];
      if (off + 1 >= slot_length[rd_slot]) begin
        r.pop_last = 1'b1;
        rd_off  = 0;
        rd_slot = (rd_slot + 1) % QUEUE_SLOTS;
      end else begin
        rd_off = off + 1;
      end
    end
    cnt = frames_held();
    r.frames_stored   = CNT_OUT_W'(cnt);
    r.free_slots      = CNT_OUT_W'(QUEUE_SLOTS - 1 - cnt);
    r.above_threshold = (cnt >= fill_level);
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    logic      bad;
    if (rst) begin
      wr_slot    = 0;
      rd_slot    = 0;
      wr_off     = 0;
      rd_off     = 0;
      dropping   = 1'b0;
      fill_level = '0;
      expected_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result at %0t: byte %0d len %0d status %0d", $time,
                     result.pop_byte, result.frame_length, result.status);
        end else begin
          want = expected_results.pop_front();
          bad  = (result.pop_byte !== want.pop_byte) ||
                 (result.pop_last !== want.pop_last) ||
                 (result.frame_length !== want.frame_length) ||
                 (result.status !== want.status) ||
                 (result.frames_stored !== want.frames_stored) ||
                 (result.free_slots !== want.free_slots) ||
                 (result.above_threshold !== want.above_threshold);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: expected byte %0d last %0d len %0d status %0d",
                       $time, want.pop_byte, want.pop_last, want.frame_length,
                       want.status);
              $display("  expected stored %0d free %0d above %0d",
                       want.frames_stored, want.free_slots, want.above_threshold);
              $display("  got byte %0d last %0d len %0d status %0d stored %0d free %0d",
                       result.pop_byte, result.pop_last, result.frame_length,
                       result.status, result.frames_stored, result.free_slots);
              $display("  got above %0d", result.above_threshold);
            end
          end
        end
      end
      if (item_valid && item_ready)
        predict_result(item);
      if (cfg_valid && cfg_ready)
        fill_level = cfg_data;
    end
    pending    <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

/* bench/frame_ring_queue_test.sv */
`timescale 1ns / 100ps
// top of the frame ring queue testbench: clock, reset, stimulus and verdict
// depends on frq_pkg, frame_ring_queue and frame_ring_queue_check
module frame_ring_queue_test;
  import frq_pkg::*;

  localparam int QUEUE_SLOTS     = 8;
  localparam int MAX_FRAME_BYTES = 2048;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_ready;
  in_item_t            item         = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  out_item_t           result;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [THRESH_W-1:0] cfg_data     = '0;

  int unsigned fail_count;
  int unsigned pending;

  // stimulus knobs shared by the sender and the receiver
  bit          quiet       = 1'b0;  // no idling on either side while set
  int unsigned stall_req   = 0;     // bumped to ask the receiver for a long hold-off
  int unsigned mid_pop_pct = 0;     // chance of a pop slipped in between frame bytes
  int unsigned sent        = 0;     // item transfers so far

  always #5 clk = ~clk;

  frame_ring_queue #(
    .QUEUE_SLOTS     (QUEUE_SLOTS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  frame_ring_queue_check #(
    .QUEUE_SLOTS     (QUEUE_SLOTS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) i_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // one item transfer: random gaps first, then valid held with a steady
  // payload until ready is seen; ready is sampled mid-cycle, where it is settled
  task automatic offer_item(input logic kind, input logic [7:0] data, input logic last);
    in_item_t it;
    bit       taken;
    it.kind      = kind;
    it.push_byte = data;
    it.push_last = last;
    while (!quiet && $urandom_range(99) < 26) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do begin
      @(negedge clk);
      taken = item_ready;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  // a well-formed frame with random bytes, pops now and then between bytes
  task automatic push_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if (mid_pop_pct != 0 && $urandom_range(99) < mid_pop_pct)
        offer_item(KIND_POP, 8'($urandom), 1'($urandom));
      offer_item(KIND_PUSH, 8'($urandom), i == len - 1);
    end
  endtask

  // pops carry random don't-care bytes and last marks
  task automatic pop_run(input int unsigned n);
    repeat (n) offer_item(KIND_POP, 8'($urandom), 1'($urandom));
  endtask

  // stop offering, wait until every expected result has come back, then
  // wait for the number of spare cycles given
  task automatic drain(input int unsigned spare);
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (spare) @(posedge clk);
  endtask

  // threshold writes happen only with the block idle
  task automatic set_threshold(input logic [THRESH_W-1:0] level);
    bit taken;
    drain(4);
    cfg_valid <= 1'b1;
    cfg_data  <= level;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random ready, a long hold-off on request, none while quiet
  initial begin
    int unsigned stall_seen;
    stall_seen = 0;
    forever begin
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        result_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        result_ready <= quiet || ($urandom_range(99) >= 26);
        @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned goal;
    int unsigned push_pct;
    int unsigned len;
    logic [THRESH_W-1:0] level;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, threshold in the middle so the flag flips while filling
    set_threshold(4'd4);
    offer_item(KIND_POP, 8'hFF, 1'b1);                  // pop on an empty queue
    for (int i = 0; i < QUEUE_SLOTS - 1; i++)          // fill every usable slot
      offer_item(KIND_PUSH, (i == 1) ? 8'hFF : 8'(i * 8'h25), 1'b1);
    offer_item(KIND_PUSH, 8'h5A, 1'b0);                 // frame arriving at a full queue
    offer_item(KIND_PUSH, 8'hA5, 1'b1);
    pop_run(QUEUE_SLOTS);                               // empty it and pop once more
    offer_item(KIND_PUSH, 8'h11, 1'b1);                 // pop while a frame is half built
    offer_item(KIND_PUSH, 8'h22, 1'b0);
    offer_item(KIND_PUSH, 8'h33, 1'b0);
    offer_item(KIND_POP, 8'h00, 1'b0);
    offer_item(KIND_PUSH, 8'h44, 1'b1);
    pop_run(4);

    // random phases, alternating push-heavy and pop-heavy traffic
    mid_pop_pct = 15;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       level = 4'd0;
        1:       level = 4'd8;
        2:       level = 4'd7;
        3:       level = 4'd1;
        4:       level = THRESH_W'($urandom_range(0, 8));
        default: level = THRESH_W'($urandom_range(9, 15));
      endcase
      set_threshold(level);
      push_pct = (ph % 2 == 1) ? 70 : 45;
      if (ph == 1)
        stall_req++;                    // receiver holds off, input side backs up
      quiet = (ph == 2);
      goal  = sent + 125;
      while (sent < goal) begin
        if ($urandom_range(99) < push_pct) begin
          len = ($urandom_range(99) < 90) ? $urandom_range(1, 10) : $urandom_range(11, 80);
          push_frame(len);
        end else begin
          pop_run($urandom_range(1, 12));
        end
      end
      quiet = 1'b0;
    end

    drain(8);
    if (fail_count == 0)
      $display("frame_ring_queue_test: clean");
    else
      $display("frame_ring_queue_test: errors");
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("frame_ring_queue_test: errors");
    $finish;
  end

endmodule
